// ===== hdl/mqd_pkg.sv =====
// Shared types and constants for the MQTT receive deframer.
// Used by the parser, the result stage and the top level; depends on nothing.
package mqd_pkg;

  // Reset value of the largest accepted PUBLISH remaining length
  localparam logic [27:0] MAX_MSG_RESET = 28'd1024;

  // Packet type nibbles handled specially
  localparam logic [3:0] TYPE_CONNACK  = 4'd2;
  localparam logic [3:0] TYPE_PUBLISH  = 4'd3;
  localparam logic [3:0] TYPE_SUBACK   = 4'd9;
  localparam logic [3:0] TYPE_PINGRESP = 4'd13;

  // Acknowledge byte values
  localparam logic [7:0] SUBACK_ID_LO  = 8'h01;
  localparam logic [7:0] SUBACK_FAIL   = 8'h80;

  // Parser phases
  typedef enum logic [2:0] {
    PH_HEADER   = 3'd0,
    PH_LENGTH   = 3'd1,
    PH_TOPIC_HI = 3'd2,
    PH_TOPIC_LO = 3'd3,
    PH_TOPIC    = 3'd4,
    PH_BODY     = 3'd5,
    PH_ACK      = 3'd6,
    PH_TRASH    = 3'd7
  } phase_t;

  // Event kinds reported on the result channel
  typedef enum logic [2:0] {
    EV_BODY      = 3'd0,
    EV_CONNACK   = 3'd1,
    EV_SUBACK    = 3'd2,
    EV_PINGRESP  = 3'd3,
    EV_OTHER     = 3'd4,
    EV_OVERSIZE  = 3'd5,
    EV_MALFORMED = 3'd6,
    EV_EMPTY     = 3'd7
  } event_t;

  // One result word from the parser to the result stage
  typedef struct packed {
    logic       valid;
    event_t     kind;
    logic [3:0] ptype;
    logic [7:0] data;
    logic       last;
    logic       acc;
  } result_t;

endpackage

// ===== hdl/mqd_parser.sv =====
// Byte-wise MQTT fixed header parser: packet state, length assembly and events.
// Depends on mqd_pkg; holds the max message size register.
module mqd_parser import mqd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [27:0] cfg_wr_data,
  input  logic        byte_acc,
  input  logic [7:0]  byte_in,
  output result_t     res
);

  logic [27:0] max_size_r;
  phase_t      phase_r, phase_nxt;
  logic [3:0]  type_r, type_nxt;
  logic [27:0] bytes_left_r, bytes_left_nxt;
  logic [1:0]  len_idx_r, len_idx_nxt;
  logic [15:0] topic_r, topic_nxt;
  logic [1:0]  body_idx_r, body_idx_nxt;
  logic        ack_ok_r, ack_ok_nxt;

  logic [27:0] len_add;
  logic [27:0] len_sum;
  logic [27:0] bl_dec;
  logic [15:0] topic_full;
  logic [15:0] topic_dec;
  logic        ack_ok_new;
  logic [1:0]  body_idx_new;
  logic        ack_need_met;
  event_t      ack_kind;

  // Place the 7 length bits of this byte at their group position
  always_comb begin
    unique case (len_idx_r)
      2'd0: len_add = {21'd0, byte_in[6:0]};
      2'd1: len_add = {14'd0, byte_in[6:0], 7'd0};
      2'd2: len_add = {7'd0, byte_in[6:0], 14'd0};
      default: len_add = {byte_in[6:0], 21'd0};
    endcase
  end

  assign len_sum    = bytes_left_r + len_add;
  assign bl_dec     = bytes_left_r - 28'd1;
  assign topic_full = {topic_r[15:8], byte_in};
  assign topic_dec  = topic_r - 16'd1;
  assign ack_kind   = (type_r == TYPE_CONNACK) ? EV_CONNACK : EV_SUBACK;

  // Check acknowledge bytes: CONNACK looks at the return code only,
  // SUBACK at the packet id and the granted code
  always_comb begin
    ack_ok_new = ack_ok_r;
    if (type_r == TYPE_CONNACK) begin
      if (body_idx_r == 2'd1) ack_ok_new = (byte_in == 8'h00);
    end else begin
      unique case (body_idx_r)
        2'd0: ack_ok_new = (byte_in == 8'h00);
        2'd1: ack_ok_new = ack_ok_r & (byte_in == SUBACK_ID_LO);
        2'd2: ack_ok_new = ack_ok_r & (byte_in != SUBACK_FAIL);
        default: ack_ok_new = ack_ok_r;
      endcase
    end
    body_idx_new = (body_idx_r == 2'd3) ? body_idx_r : body_idx_r + 2'd1;
    // CONNACK needs two bytes seen, SUBACK three
    ack_need_met = (type_r == TYPE_CONNACK) ? (body_idx_new >= 2'd2)
                                            : (body_idx_new == 2'd3);
  end

  // Next state and result for the byte in flight
  always_comb begin
    phase_nxt      = phase_r;
    type_nxt       = type_r;
    bytes_left_nxt = bytes_left_r;
    len_idx_nxt    = len_idx_r;
    topic_nxt      = topic_r;
    body_idx_nxt   = body_idx_r;
    ack_ok_nxt     = ack_ok_r;
    res            = '0;
    res.ptype      = type_r;

    unique case (phase_r)
      PH_HEADER: begin
        type_nxt       = byte_in[7:4];
        bytes_left_nxt = '0;
        len_idx_nxt    = '0;
        phase_nxt      = PH_LENGTH;
      end
      PH_LENGTH: begin
        bytes_left_nxt = len_sum;
        if (byte_in[7]) begin
          if (len_idx_r == 2'd3) begin
            // fifth length byte would follow
            phase_nxt = PH_HEADER;
            res.valid = 1'b1;
            res.kind  = EV_MALFORMED;
          end else begin
            len_idx_nxt = len_idx_r + 2'd1;
          end
        end else if (type_r == TYPE_PUBLISH) begin
          if (len_sum > max_size_r) begin
            phase_nxt = PH_TRASH;
            res.valid = 1'b1;
            res.kind  = EV_OVERSIZE;
          end else if (len_sum == '0) begin
            phase_nxt = PH_HEADER;
            res.valid = 1'b1;
            res.kind  = EV_MALFORMED;
          end else begin
            phase_nxt = PH_TOPIC_HI;
          end
        end else if (type_r == TYPE_CONNACK || type_r == TYPE_SUBACK) begin
          body_idx_nxt = '0;
          ack_ok_nxt   = 1'b0;
          if (len_sum == '0) begin
            phase_nxt = PH_HEADER;
            res.valid = 1'b1;
            res.kind  = ack_kind;
          end else begin
            phase_nxt = PH_ACK;
          end
        end else begin
          phase_nxt = (len_sum == '0) ? PH_HEADER : PH_TRASH;
          res.valid = 1'b1;
          res.kind  = (type_r == TYPE_PINGRESP) ? EV_PINGRESP : EV_OTHER;
        end
      end
      PH_TOPIC_HI: begin
        bytes_left_nxt = bl_dec;
        topic_nxt      = {byte_in, 8'h00};
        if (bl_dec == '0) begin
          phase_nxt = PH_HEADER;
          res.valid = 1'b1;
          res.kind  = EV_MALFORMED;
        end else begin
          phase_nxt = PH_TOPIC_LO;
        end
      end
      PH_TOPIC_LO: begin
        bytes_left_nxt = bl_dec;
        topic_nxt      = topic_full;
        if ({12'd0, topic_full} > bl_dec) begin
          // topic runs past the end of the packet
          phase_nxt = (bl_dec == '0) ? PH_HEADER : PH_TRASH;
          res.valid = 1'b1;
          res.kind  = EV_MALFORMED;
        end else if (topic_full == '0) begin
          if (bl_dec == '0) begin
            phase_nxt = PH_HEADER;
            res.valid = 1'b1;
            res.kind  = EV_EMPTY;
          end else begin
            phase_nxt = PH_BODY;
          end
        end else begin
          phase_nxt = PH_TOPIC;
        end
      end
      PH_TOPIC: begin
        bytes_left_nxt = bl_dec;
        topic_nxt      = topic_dec;
        if (topic_dec == '0) begin
          if (bl_dec == '0) begin
            phase_nxt = PH_HEADER;
            res.valid = 1'b1;
            res.kind  = EV_EMPTY;
          end else begin
            phase_nxt = PH_BODY;
          end
        end
      end
      PH_BODY: begin
        bytes_left_nxt = bl_dec;
        res.valid      = 1'b1;
        res.kind       = EV_BODY;
        res.data       = byte_in;
        res.last       = (bl_dec == '0);
        if (bl_dec == '0) phase_nxt = PH_HEADER;
      end
      PH_ACK: begin
        bytes_left_nxt = bl_dec;
        ack_ok_nxt     = ack_ok_new;
        body_idx_nxt   = body_idx_new;
        if (bl_dec == '0) begin
          phase_nxt = PH_HEADER;
          res.valid = 1'b1;
          res.kind  = ack_kind;
          res.acc   = ack_ok_new & ack_need_met;
        end
      end
      PH_TRASH: begin
        // drop the rest of the packet
        if (bytes_left_r != '0) bytes_left_nxt = bl_dec;
        if (bytes_left_r == '0 || bl_dec == '0) phase_nxt = PH_HEADER;
      end
      default: begin
        phase_nxt = PH_HEADER;
      end
    endcase

    if (!byte_acc) res.valid = 1'b0;
  end

  // Hold the size limit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_size_r <= MAX_MSG_RESET;
    end else if (cfg_wr_en) begin
      max_size_r <= cfg_wr_data;
    end
  end

  // Advance parser state on each accepted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HEADER;
      type_r       <= '0;
      bytes_left_r <= '0;
      len_idx_r    <= '0;
      topic_r      <= '0;
      body_idx_r   <= '0;
      ack_ok_r     <= 1'b0;
    end else if (byte_acc) begin
      phase_r      <= phase_nxt;
      type_r       <= type_nxt;
      bytes_left_r <= bytes_left_nxt;
      len_idx_r    <= len_idx_nxt;
      topic_r      <= topic_nxt;
      body_idx_r   <= body_idx_nxt;
      ack_ok_r     <= ack_ok_nxt;
    end
  end

endmodule

// ===== hdl/mqd_out_stage.sv =====
// Result register between the parser and the output stream.
// Depends on mqd_pkg for the result word type.
module mqd_out_stage import mqd_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    byte_acc,
  input  result_t res,
  output logic    slot_free,
  input  logic    out_tready,
  output logic    out_valid,
  output result_t out_res
);

  logic    valid_r;
  result_t res_r;

  // A new word may enter when the slot is empty or draining this cycle
  assign slot_free = !valid_r || out_tready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  // Hold valid until the word is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (byte_acc) begin
      valid_r <= res.valid;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  // Load payload with each accepted byte
  always_ff @(posedge clk) begin
    if (byte_acc) begin
      res_r <= res;
    end
  end

endmodule

// ===== hdl/mqtt_rx_packet_deframer.sv =====
// Top level of the MQTT receive deframer: input stream, parser, result stream.
// Depends on mqd_pkg, mqd_parser and mqd_out_stage.
//
// Takes one received MQTT byte per cycle and gives at most one word per byte,
// in the cycle after the byte is taken; a steady rate of one byte per clock
// holds as long as the result side keeps out_tready high. The rate is set by
// the single parser state update per byte, feeding one result register. The
// fixed header is parsed, PUBLISH topics skipped, body bytes stream out with
// tlast on the last one; acknowledge, ping and other packets give one event
// word. cfg_wr_data sets the largest PUBLISH length accepted (reset 1024);
// the user must write it only while the block is idle; no logic enforces it.
module mqtt_rx_packet_deframer import mqd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [27:0] cfg_wr_data,   // max_message_size
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,      // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,     // [7:0] data_byte, [8] accepted, rest zero
  output logic [6:0]  out_tuser,     // [2:0] event_kind, [6:3] packet_type
  output logic        out_tlast      // last_byte
);

  logic    byte_acc;
  logic    slot_free;
  result_t res;
  result_t out_res;

  assign in_tready = slot_free;
  assign byte_acc  = in_tvalid && slot_free;

  mqd_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .byte_acc    (byte_acc),
    .byte_in     (in_tdata),
    .res         (res)
  );

  mqd_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_acc   (byte_acc),
    .res        (res),
    .slot_free  (slot_free),
    .out_tready (out_tready),
    .out_valid  (out_tvalid),
    .out_res    (out_res)
  );

  // Pack the result word onto the stream
  assign out_tdata = {7'd0, out_res.acc, out_res.data};
  assign out_tuser = {out_res.ptype, out_res.kind};
  assign out_tlast = out_res.last;

endmodule

// ===== test/mqd_deframe_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the MQTT receive deframer: watches the byte, result and config ports.
// Predicts each result word from the accepted link bytes and compares it; depends on mqd_pkg.
module mqd_deframe_checker import mqd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [27:0] cfg_wr_data,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,
  input  logic [6:0]  out_tuser,
  input  logic        out_tlast,
  output int          errors,
  output int          outstanding,
  output int          bytes_taken,
  output int          words_seen,
  output logic [7:0]  kinds_seen
);

  typedef struct packed {
    event_t     kind;
    logic [3:0] ptype;
    logic [7:0] data;
    logic       last;
    logic       acc;
  } deframe_word_t;

  // Parser copy kept by the scoreboard
  phase_t      rx_phase;
  logic [3:0]  pkt_type;
  logic [27:0] remaining;
  logic [1:0]  len_count;
  logic [15:0] topic_count;
  logic [1:0]  ack_count;
  logic        ack_good;
  logic [27:0] max_size;

  deframe_word_t expected_words[$];

  task automatic expect_word(input event_t kind, input logic [7:0] data, input logic last,
                             input logic acc);
    deframe_word_t w;
    w.kind  = kind;
    w.ptype = pkt_type;
    w.data  = data;
    w.last  = last;
    w.acc   = acc;
    expected_words.push_back(w);
  endtask

  // Drop the rest of the packet, or go straight back to the header if nothing is left
  task automatic skip_rest();
    rx_phase = (remaining == 0) ? PH_HEADER : PH_TRASH;
  endtask

  // Report a CONNACK or SUBACK once its packet has ended
  task automatic report_ack();
    logic is_connack;
    logic [1:0] need;
    is_connack = (pkt_type == TYPE_CONNACK);
    need = is_connack ? 2'd2 : 2'd3;
    rx_phase = PH_HEADER;
    expect_word(is_connack ? EV_CONNACK : EV_SUBACK, 8'h00, 1'b0,
                ack_good && (ack_count >= need));
  endtask

  task automatic finish_topic();
    if (remaining == 0) begin
      rx_phase = PH_HEADER;
      expect_word(EV_EMPTY, 8'h00, 1'b0, 1'b0);
    end else begin
      rx_phase = PH_BODY;
    end
  endtask

  // Advance the parser copy by one received byte
  task automatic deframe_byte(input logic [7:0] b);
    case (rx_phase)
      PH_HEADER: begin
        pkt_type  = b[7:4];
        remaining = '0;
        len_count = '0;
        rx_phase  = PH_LENGTH;
      end
      PH_LENGTH: begin
        remaining = remaining + ({21'd0, b[6:0]} << (7 * len_count));
        if (b[7]) begin
          if (len_count == 2'd3) begin
            rx_phase = PH_HEADER;
            expect_word(EV_MALFORMED, 8'h00, 1'b0, 1'b0);
          end else begin
            len_count = len_count + 2'd1;
          end
        end else if (pkt_type == TYPE_PUBLISH) begin
          if (remaining > max_size) begin
            skip_rest();
            expect_word(EV_OVERSIZE, 8'h00, 1'b0, 1'b0);
          end else if (remaining == 0) begin
            rx_phase = PH_HEADER;
            expect_word(EV_MALFORMED, 8'h00, 1'b0, 1'b0);
          end else begin
            rx_phase = PH_TOPIC_HI;
          end
        end else if (pkt_type == TYPE_CONNACK || pkt_type == TYPE_SUBACK) begin
          ack_count = '0;
          ack_good  = 1'b0;
          if (remaining == 0) report_ack();
          else rx_phase = PH_ACK;
        end else begin
          skip_rest();
          expect_word((pkt_type == TYPE_PINGRESP) ? EV_PINGRESP : EV_OTHER,
                      8'h00, 1'b0, 1'b0);
        end
      end
      PH_TOPIC_HI: begin
        remaining   = remaining - 28'd1;
        topic_count = {b, 8'h00};
        if (remaining == 0) begin
          rx_phase = PH_HEADER;
          expect_word(EV_MALFORMED, 8'h00, 1'b0, 1'b0);
        end else begin
          rx_phase = PH_TOPIC_LO;
        end
      end
      PH_TOPIC_LO: begin
        remaining   = remaining - 28'd1;
        topic_count = topic_count | {8'h00, b};
        if ({12'd0, topic_count} > remaining) begin
          skip_rest();
          expect_word(EV_MALFORMED, 8'h00, 1'b0, 1'b0);
        end else if (topic_count == 0) begin
          finish_topic();
        end else begin
          rx_phase = PH_TOPIC;
        end
      end
      PH_TOPIC: begin
        remaining   = remaining - 28'd1;
        topic_count = topic_count - 16'd1;
        if (topic_count == 0) finish_topic();
      end
      PH_BODY: begin
        remaining = remaining - 28'd1;
        if (remaining == 0) begin
          rx_phase = PH_HEADER;
          expect_word(EV_BODY, b, 1'b1, 1'b0);
        end else begin
          expect_word(EV_BODY, b, 1'b0, 1'b0);
        end
      end
      PH_ACK: begin
        remaining = remaining - 28'd1;
        if (pkt_type == TYPE_CONNACK) begin
          if (ack_count == 2'd1) ack_good = (b == 8'h00);
        end else begin
          case (ack_count)
            2'd0: ack_good = (b == 8'h00);
            2'd1: ack_good = ack_good & (b == SUBACK_ID_LO);
            2'd2: ack_good = ack_good & (b != SUBACK_FAIL);
            default: ;
          endcase
        end
        if (ack_count != 2'd3) ack_count = ack_count + 2'd1;
        if (remaining == 0) report_ack();
      end
      default: begin
        if (remaining != 0) remaining = remaining - 28'd1;
        if (remaining == 0) rx_phase = PH_HEADER;
      end
    endcase
  endtask

  always @(posedge clk) begin
    deframe_word_t want;
    deframe_word_t got;
    if (!rst_n) begin
      rx_phase    = PH_HEADER;
      pkt_type    = '0;
      remaining   = '0;
      len_count   = '0;
      topic_count = '0;
      ack_count   = '0;
      ack_good    = 1'b0;
      max_size    = MAX_MSG_RESET;
      expected_words.delete();
      errors      = 0;
      bytes_taken = 0;
      words_seen  = 0;
      kinds_seen  = '0;
    end else begin
      // Compare the result word first: it stems from an earlier byte
      if (out_tvalid && out_tready) begin
        got.kind  = event_t'(out_tuser[2:0]);
        got.ptype = out_tuser[6:3];
        got.data  = out_tdata[7:0];
        got.acc   = out_tdata[8];
        got.last  = out_tlast;
        words_seen++;
        kinds_seen[out_tuser[2:0]] = 1'b1;
        if (expected_words.size() == 0) begin
          errors++;
          if (errors <= 30)
            $display("%0t: unexpected word, expected none, got kind=%0d type=%0d tdata=%04h last=%b",
                     $time, out_tuser[2:0], out_tuser[6:3], out_tdata, out_tlast);
        end else begin
          want = expected_words.pop_front();
          if (got.kind != want.kind || got.ptype != want.ptype || got.data != want.data ||
              got.last != want.last || got.acc != want.acc || out_tdata[15:9] != 7'd0) begin
            errors++;
            if (errors <= 30)
              $display("%0t: word mismatch, expected kind=%0d type=%0d data=%02h last=%b acc=%b, got kind=%0d type=%0d tdata=%04h last=%b",
                       $time, want.kind, want.ptype, want.data, want.last, want.acc,
                       out_tuser[2:0], out_tuser[6:3], out_tdata, out_tlast);
          end
        end
      end
      if (cfg_wr_en) max_size = cfg_wr_data;
      if (in_tvalid && in_tready) begin
        bytes_taken++;
        deframe_byte(in_tdata);
      end
    end
    outstanding = expected_words.size();
  end

endmodule

// ===== test/tb_mqtt_rx_packet_deframer.sv =====
`timescale 1ns / 100ps
// Top of the MQTT receive deframer testbench: clock, reset, link byte stimulus and verdict.
// Depends on mqd_pkg, the deframer RTL and mqd_deframe_checker.
module tb_mqtt_rx_packet_deframer;
  import mqd_pkg::*;

  localparam int IDLE_LIMIT  = 4000;
  localparam int PHASE_BYTES = 210;

  // Hand-picked opening sequence, one packet per line
  localparam logic [7:0] SMOKE_BYTES [26] = '{
    8'h20, 8'h02, 8'h00, 8'h00,               // CONNACK, return code zero
    8'h90, 8'h03, 8'h00, 8'h01, 8'h80,        // SUBACK refused
    8'hD0, 8'h00,                             // PINGRESP
    8'h30, 8'h04, 8'h00, 8'h01, 8'h7A, 8'hFF, // PUBLISH, one topic byte, one body byte
    8'h30, 8'h02, 8'h00, 8'h00,               // PUBLISH with an empty body
    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF         // fifth length byte on type 15
  };

  // Remaining-length limits per phase; -1 picks a random small limit
  localparam int PHASE_LIMITS [8] = '{1024, 0, 268435455, 5, 64, 300, -1, 1024};

  typedef enum int {
    PKT_PUBLISH, PKT_TINY, PKT_LONG_TOPIC, PKT_OVERSIZE,
    PKT_CONNACK, PKT_SUBACK, PKT_PING, PKT_OTHER
  } pkt_kind_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [27:0] cfg_wr_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic [6:0]  out_tuser;
  logic        out_tlast;

  int         errors;
  int         outstanding;
  int         bytes_taken;
  int         words_seen;
  logic [7:0] kinds_seen;

  logic [7:0]  link_bytes[$];
  logic [7:0]  frame_bytes[$];
  logic [27:0] size_limit;
  int          idle_cycles = 0;
  int          ready_mode = 0;
  int          ready_left = 0;
  int unsigned ready_tick = 0;

  mqtt_rx_packet_deframer dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

  mqd_deframe_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .errors      (errors),
    .outstanding (outstanding),
    .bytes_taken (bytes_taken),
    .words_seen  (words_seen),
    .kinds_seen  (kinds_seen)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Result side: switch between always ready, random, periodic and heavy stalls
  always @(negedge clk) begin
    if (ready_left == 0) begin
      ready_mode = $urandom_range(0, 3);
      ready_left = $urandom_range(16, 96);
    end else begin
      ready_left--;
    end
    ready_tick++;
    case (ready_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom_range(0, 1));
      2: out_tready <= (ready_tick % 3) != 0;
      default: out_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // Stop the run when no word moves on either side for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Encode a remaining length, sometimes padded with zero groups up to four bytes
  task automatic put_length(input int len);
    int groups;
    int total;
    groups = 1;
    while (groups < 4 && (len >> (7 * groups)) != 0) groups++;
    total = groups;
    if ($urandom_range(0, 4) == 0) total = $urandom_range(groups, 4);
    for (int i = 0; i < total; i++)
      frame_bytes.push_back(8'((len >> (7 * i)) & 127) | ((i < total - 1) ? 8'h80 : 8'h00));
  endtask

  // Append one packet, a fifth-length-byte header, noise or a cut-off packet
  task automatic add_random_packet();
    int          pick;
    int          len;
    int          cut;
    logic [15:0] topic;
    logic [3:0]  ptype;
    logic [7:0]  b;
    pkt_kind_t   kind;
    frame_bytes.delete();
    pick = $urandom_range(0, 99);
    if (pick < 7) begin
      // Noise: random header, small values after it, then drain back to a header
      frame_bytes.push_back(8'($urandom));
      repeat ($urandom_range(1, 6)) frame_bytes.push_back(8'($urandom_range(0, 15)));
      repeat (17) frame_bytes.push_back(8'h00);
      frame_bytes.push_back(8'h80);
      frame_bytes.push_back(8'h00);
    end else if (pick < 11) begin
      // Four length bytes that all ask for one more
      frame_bytes.push_back(8'($urandom));
      repeat (4) frame_bytes.push_back(8'h80 | 8'($urandom_range(0, 127)));
    end else begin
      pick  = $urandom_range(0, 99);
      kind  = (pick < 36) ? PKT_PUBLISH : (pick < 40) ? PKT_TINY :
              (pick < 45) ? PKT_LONG_TOPIC : (pick < 50) ? PKT_OVERSIZE :
              (pick < 62) ? PKT_CONNACK : (pick < 76) ? PKT_SUBACK :
              (pick < 84) ? PKT_PING : PKT_OTHER;
      if (kind == PKT_OVERSIZE && size_limit >= 400) kind = PKT_PUBLISH;
      topic = '0;
      case (kind)
        PKT_PUBLISH: begin
          ptype = TYPE_PUBLISH;
          len   = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 300) : $urandom_range(2, 24);
          topic = 16'($urandom_range(0, len - 2));
        end
        PKT_TINY: begin
          ptype = TYPE_PUBLISH;
          len   = $urandom_range(0, 1);
        end
        PKT_LONG_TOPIC: begin
          ptype = TYPE_PUBLISH;
          len   = $urandom_range(2, 20);
          topic = $urandom_range(0, 1) ? 16'($urandom_range(len - 1, len + 3))
                                       : 16'($urandom_range(len - 1, 65535));
        end
        PKT_OVERSIZE: begin
          ptype = TYPE_PUBLISH;
          len   = int'(size_limit) + $urandom_range(1, 9);
        end
        PKT_CONNACK: begin
          ptype = TYPE_CONNACK;
          len   = ($urandom_range(0, 9) < 7) ? 2 : $urandom_range(0, 4);
        end
        PKT_SUBACK: begin
          ptype = TYPE_SUBACK;
          len   = ($urandom_range(0, 9) < 7) ? 3 : $urandom_range(0, 5);
        end
        PKT_PING: begin
          ptype = TYPE_PINGRESP;
          len   = $urandom_range(0, 3);
        end
        default: begin
          ptype = 4'($urandom);
          while (ptype == TYPE_CONNACK || ptype == TYPE_PUBLISH || ptype == TYPE_SUBACK ||
                 ptype == TYPE_PINGRESP)
            ptype = 4'($urandom);
          len = $urandom_range(0, 8);
        end
      endcase
      frame_bytes.push_back({ptype, 4'($urandom)});
      put_length(len);
      for (int i = 0; i < len; i++) begin
        b = 8'($urandom);
        case (kind)
          PKT_PUBLISH, PKT_LONG_TOPIC: begin
            if (i == 0) b = topic[15:8];
            else if (i == 1) b = topic[7:0];
          end
          PKT_CONNACK: if (i == 1 && $urandom_range(0, 1)) b = 8'h00;
          PKT_SUBACK: begin
            if (i == 0 && $urandom_range(0, 4) != 0) b = 8'h00;
            else if (i == 1 && $urandom_range(0, 4) != 0) b = SUBACK_ID_LO;
            else if (i == 2 && $urandom_range(0, 9) < 3) b = SUBACK_FAIL;
          end
          default: ;
        endcase
        frame_bytes.push_back(b);
      end
      // Cut some packets short, then drain with zeros and resync on a header
      if ($urandom_range(0, 99) < 7) begin
        cut = $urandom_range(1, frame_bytes.size() - 1);
        while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
        repeat (len + 2) frame_bytes.push_back(8'h00);
        frame_bytes.push_back(8'h80);
        frame_bytes.push_back(8'h00);
      end
    end
    foreach (frame_bytes[i]) link_bytes.push_back(frame_bytes[i]);
  endtask

  // Send the queued bytes in bursts separated by random gaps
  task automatic send_link_bytes(input int max_gap);
    int burst_left;
    int gap;
    burst_left = $urandom_range(0, 23);
    while (link_bytes.size() != 0) begin
      in_tdata  <= link_bytes.pop_front();
      in_tvalid <= 1'b1;
      @(posedge clk);
      while (!in_tready) @(posedge clk);
      @(negedge clk);
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(0, 23);
        gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
        if (gap != 0) begin
          in_tvalid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
    end
    in_tvalid <= 1'b0;
  endtask

  // Hold until every predicted word has come out, then let the pipeline settle
  task automatic wait_drained();
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_size_limit(input logic [27:0] value);
    cfg_wr_data <= value;
    cfg_wr_en   <= 1'b1;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    size_limit = value;
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    size_limit = MAX_MSG_RESET;

    foreach (SMOKE_BYTES[i]) link_bytes.push_back(SMOKE_BYTES[i]);
    send_link_bytes(0);
    wait_drained();

    // One phase per size limit; the first keeps the reset value
    foreach (PHASE_LIMITS[p]) begin
      if (p != 0)
        write_size_limit((PHASE_LIMITS[p] < 0) ? 28'($urandom_range(2, 350))
                                               : 28'(PHASE_LIMITS[p]));
      while (link_bytes.size() < PHASE_BYTES) add_random_packet();
      send_link_bytes((p % 3 == 2) ? 0 : 6);
      wait_drained();
    end

    repeat (10) @(negedge clk);
    $display("Run covered %0d link bytes, %0d result words, %0d size limits incl. 0 and max",
             bytes_taken, words_seen, 8);
    $display("Event kinds seen (bit per kind, 7..0): %b", kinds_seen);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/mqd_pkg.sv
hdl/mqd_parser.sv
hdl/mqd_out_stage.sv
hdl/mqtt_rx_packet_deframer.sv
test/mqd_deframe_checker.sv
test/tb_mqtt_rx_packet_deframer.sv
